// ===== src/dq_pkg.sv =====
// Shared types and constants for the double-ended queue.
package dq_pkg;

  // Default number of storage entries.
  localparam int DQ_DEPTH_DEF = 16;

  // Data word width of one entry.
  localparam int DQ_WORD_W = 32;

  // Operation codes carried by a request.
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  // Status codes returned with every result.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_ENDS,
    S_OUT
  } state_t;

endpackage

// ===== src/double_ended_queue_core.sv =====
// Double-ended queue held as a ring buffer in a synchronous memory.
// The sequencer updates the pointers in S_IDLE when it accepts a request,
// reads the new front and back entries in S_ENDS and loads the result in
// S_OUT once the output is free; it takes no new request until then.
// Reset clears the state, the front pointer, the item count and the output
// valid flag; the storage is not cleared, and only written words are shown.
module double_ended_queue_core import dq_pkg::*; #(
  parameter  int DEPTH = DQ_DEPTH_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_kind,
  input  logic signed [DQ_WORD_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [DQ_WORD_W-1:0] out_popped_value,
  output logic signed [DQ_WORD_W-1:0] out_front_value,
  output logic signed [DQ_WORD_W-1:0] out_back_value,
  output logic [CW-1:0]               out_item_count,
  output logic [1:0]                  out_status
);

  // Position base + off modulo DEPTH, with off at most DEPTH.
  function automatic logic [AW-1:0] wrap_pos(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + (AW+1)'(off);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  state_t               state_r, state_nxt;
  logic [AW-1:0]        front_r, front_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  status_t              status_r, status_nxt;
  logic                 pop_ok_r, pop_ok_nxt;
  logic [DQ_WORD_W-1:0] popped_r, popped_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [DQ_WORD_W-1:0] out_popped_r, out_front_r, out_back_r;
  logic [CW-1:0]        out_count_r;
  status_t              out_status_r;
  logic                 out_load;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic                 mem_re_a, mem_re_b;
  logic [AW-1:0]        mem_raddr_a, mem_raddr_b;
  logic [DQ_WORD_W-1:0] mem_rdata_a, mem_rdata_b;

  logic                 is_full, is_empty;
  logic [AW-1:0]        front_dec, front_inc, tail_pos, last_pos;

  // Pointer arithmetic on the current state.
  always_comb begin
    is_full   = (count_r == CW'(DEPTH));
    is_empty  = (count_r == '0);
    front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
    front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);
    tail_pos  = wrap_pos(front_r, count_r);
    last_pos  = wrap_pos(front_r, count_r - CW'(1));
  end

  // Sequencer: next state, pointer update and memory accesses.
  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    count_nxt   = count_r;
    status_nxt  = status_r;
    pop_ok_nxt  = pop_ok_r;
    popped_nxt  = popped_r;
    mem_we      = 1'b0;
    mem_waddr   = tail_pos;
    mem_re_a    = 1'b0;
    mem_raddr_a = front_r;
    mem_re_b    = 1'b0;
    mem_raddr_b = last_pos;
    out_load    = 1'b0;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt  = S_ENDS;
          status_nxt = ST_DONE;
          pop_ok_nxt = 1'b0;
          case (op_t'(in_kind))
            OP_PUSH_FRONT: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = tail_pos;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                mem_re_a    = 1'b1;
                mem_raddr_a = front_r;
                front_nxt   = front_inc;
                count_nxt   = count_r - CW'(1);
                pop_ok_nxt  = 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                mem_re_a    = 1'b1;
                mem_raddr_a = last_pos;
                count_nxt   = count_r - CW'(1);
                pop_ok_nxt  = 1'b1;
              end
            end
            default: begin
              status_nxt = ST_DONE;
            end
          endcase
        end
      end
      S_ENDS: begin
        // Capture the popped word and fetch the new front and back entries.
        popped_nxt  = pop_ok_r ? mem_rdata_a : '0;
        mem_re_a    = 1'b1;
        mem_raddr_a = front_r;
        mem_re_b    = 1'b1;
        mem_raddr_b = last_pos;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid flag.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Per-request working registers.
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    pop_ok_r <= pop_ok_nxt;
    popped_r <= popped_nxt;
  end

  // Result register; front and back read zero while the queue is empty.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_popped_r <= popped_r;
      out_front_r  <= is_empty ? '0 : mem_rdata_a;
      out_back_r   <= is_empty ? '0 : mem_rdata_b;
      out_count_r  <= count_r;
      out_status_r <= status_r;
    end
  end

  dq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (in_value),
    .re_a    (mem_re_a),
    .raddr_a (mem_raddr_a),
    .rdata_a (mem_rdata_a),
    .re_b    (mem_re_b),
    .raddr_b (mem_raddr_b),
    .rdata_b (mem_rdata_b)
  );

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_popped_r;
  assign out_front_value  = out_front_r;
  assign out_back_value   = out_back_r;
  assign out_item_count   = out_count_r;
  assign out_status       = out_status_r;

endmodule

// ===== src/dq_mem.sv =====
// Storage memory: one write port and two registered read ports.
module dq_mem import dq_pkg::*; #(
  parameter int DEPTH = DQ_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [DQ_WORD_W-1:0] wdata,
  input  logic                 re_a,
  input  logic [AW-1:0]        raddr_a,
  output logic [DQ_WORD_W-1:0] rdata_a,
  input  logic                 re_b,
  input  logic [AW-1:0]        raddr_b,
  output logic [DQ_WORD_W-1:0] rdata_b
);

  logic [DQ_WORD_W-1:0] mem_r [DEPTH];
  logic [DQ_WORD_W-1:0] rdata_a_r;
  logic [DQ_WORD_W-1:0] rdata_b_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read ports hold their data until the next enabled read.
  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a_r <= mem_r[raddr_a];
    end
    if (re_b) begin
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== src/dq_chk.sv =====
// Port-level checker for the double-ended queue, bound to the top level.
module dq_chk import dq_pkg::*; #(
  parameter  int DEPTH = DQ_DEPTH_DEF,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [DQ_WORD_W-1:0] out_popped_value,
  input logic signed [DQ_WORD_W-1:0] out_front_value,
  input logic signed [DQ_WORD_W-1:0] out_back_value,
  input logic [CW-1:0]               out_item_count,
  input logic [1:0]                  out_status
);

  // A full rejection only happens with every entry in use.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |->
      out_item_count == CW'(DEPTH) && out_popped_value == '0)
    else $error("full status with a queue that is not full");

  // An empty rejection leaves an empty queue and gives only zeros.
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |->
      out_item_count == '0 && out_popped_value == '0)
    else $error("empty status with a queue that is not empty");

  // An empty queue shows zero at both ends.
  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_count == '0 |->
      out_front_value == '0 && out_back_value == '0)
    else $error("nonzero end value on an empty queue");

  // One request at a time: the input closes right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_front_value) && $stable(out_item_count))
    else $error("result changed while stalled");

endmodule

bind double_ended_queue_core dq_chk #(.DEPTH(DEPTH)) u_dq_chk (.*);

// ===== tb/sv/double_ended_queue_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the double-ended queue core, driven with directed and random requests.
module double_ended_queue_core_tb;
  import dq_pkg::*;

  localparam int DEPTH     = DQ_DEPTH_DEF;
  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int RAND_REQS = 1300;

  // One pending request for the sender.
  typedef struct {
    op_t         kind;
    logic [31:0] word;
    bit          hold;
  } deque_req_t;

  // The outcome that one request should produce.
  typedef struct {
    logic [31:0]   popped;
    logic [31:0]   front;
    logic [31:0]   back;
    logic [CW-1:0] count;
    status_t       status;
  } deque_outcome_t;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  logic [1:0]                  in_kind   = OP_PUSH_FRONT;
  logic signed [DQ_WORD_W-1:0] in_value  = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [DQ_WORD_W-1:0] out_popped_value;
  logic signed [DQ_WORD_W-1:0] out_front_value;
  logic signed [DQ_WORD_W-1:0] out_back_value;
  logic [CW-1:0]               out_item_count;
  logic [1:0]                  out_status;

  deque_req_t     req_q[$];
  deque_outcome_t outcome_q[$];
  int             fail_cnt   = 0;
  int             accept_cnt = 0;
  int             result_cnt = 0;
  int             total_reqs = 0;
  int             shadow_cnt = 0;

  // Model of the deque contents.
  logic [31:0]   dq_mem [DEPTH];
  logic [AW-1:0] dq_head  = '0;
  logic [CW-1:0] dq_count = '0;

  double_ended_queue_core #(.DEPTH(DEPTH)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_value (out_popped_value),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value),
    .out_item_count   (out_item_count),
    .out_status       (out_status)
  );

  always #1 clk = ~clk;

  // Apply one operation to the model and return what the core should report.
  function automatic deque_outcome_t deque_apply(op_t kind, logic [31:0] word);
    deque_outcome_t res;
    logic [AW-1:0]  tail;
    res.popped = '0;
    res.front  = '0;
    res.back   = '0;
    res.status = ST_DONE;
    case (kind)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (dq_count == DEPTH) begin
          res.status = ST_FULL;
        end else if (kind == OP_PUSH_FRONT) begin
          dq_head         = dq_head - 1'b1;
          dq_mem[dq_head] = word;
          dq_count        = dq_count + 1'b1;
        end else begin
          tail         = dq_head + dq_count[AW-1:0];
          dq_mem[tail] = word;
          dq_count     = dq_count + 1'b1;
        end
      end
      default: begin
        if (dq_count == 0) begin
          res.status = ST_EMPTY;
        end else if (kind == OP_POP_FRONT) begin
          res.popped = dq_mem[dq_head];
          dq_head    = dq_head + 1'b1;
          dq_count   = dq_count - 1'b1;
        end else begin
          tail       = dq_head + dq_count[AW-1:0] - 1'b1;
          res.popped = dq_mem[tail];
          dq_count   = dq_count - 1'b1;
        end
      end
    endcase
    // The ends read zero while the queue is empty.
    if (dq_count != 0) begin
      tail      = dq_head + dq_count[AW-1:0] - 1'b1;
      res.front = dq_mem[dq_head];
      res.back  = dq_mem[tail];
    end
    res.count = dq_count;
    return res;
  endfunction

  // Queue a request and track the occupancy it leaves behind.
  function automatic void add_req(op_t kind, logic [31:0] word, bit hold);
    deque_req_t r;
    r.kind = kind;
    r.word = word;
    r.hold = hold;
    req_q.push_back(r);
    if (kind == OP_PUSH_FRONT || kind == OP_PUSH_BACK) begin
      if (shadow_cnt < DEPTH) shadow_cnt++;
    end else if (shadow_cnt > 0) begin
      shadow_cnt--;
    end
  endfunction

  // Random data word, with the extremes mixed in.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Compare one field and report the first few mismatches.
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("mismatch on %s in result %0d: expected %h, got %h",
                 name, result_cnt, want, got);
    end
  endtask

  // Build the request list, release reset and wait for the run to drain.
  initial begin : stimulus
    int  seg;
    int  n;
    bit  push;
    op_t kind;
    int  rand_cnt;

    // Pops on an empty queue, extreme words, a front push that wraps the pointer.
    add_req(OP_POP_FRONT,  rand_word(),  1'b0);
    add_req(OP_POP_BACK,   rand_word(),  1'b0);
    add_req(OP_PUSH_FRONT, 32'h8000_0000, 1'b0);
    add_req(OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b0);
    add_req(OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0);
    add_req(OP_PUSH_BACK,  32'h0000_0000, 1'b0);
    add_req(OP_POP_BACK,   32'h0000_0000, 1'b0);
    add_req(OP_POP_FRONT,  32'hFFFF_FFFF, 1'b0);
    add_req(OP_POP_BACK,   32'h0000_0000, 1'b0);
    add_req(OP_POP_FRONT,  32'h0000_0000, 1'b0);
    add_req(OP_POP_BACK,   32'h0000_0000, 1'b0);
    // Fill to capacity from both ends, then push once more to see the full status.
    for (int i = 0; i <= DEPTH; i++)
      add_req(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, rand_word(), 1'b0);

    // Random segments: fill past full, drain past empty, mixed traffic and noise.
    rand_cnt = 0;
    while (rand_cnt < RAND_REQS) begin
      seg = $urandom_range(0, 9);
      if (seg < 3)      n = (DEPTH - shadow_cnt) + $urandom_range(1, 3);
      else if (seg < 6) n = shadow_cnt + $urandom_range(1, 3);
      else if (seg < 9) n = $urandom_range(10, 40);
      else              n = $urandom_range(3, 10);
      for (int i = 0; i < n; i++) begin
        if (seg < 3)      push = 1'b1;
        else if (seg < 6) push = 1'b0;
        else              push = 1'($urandom_range(0, 1));
        if (seg == 9) kind = op_t'($urandom_range(0, 3));
        else if (push) kind = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        else kind = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        add_req(kind, rand_word(), (rand_cnt == 0) || ($urandom_range(0, 63) == 0));
        rand_cnt++;
      end
    end
    total_reqs = req_q.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Every request taken, every result back, then a few quiet cycles.
    while (accept_cnt < total_reqs) @(negedge clk);
    while (outcome_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("double_ended_queue_core_tb: clean");
    end else begin
      $display("double_ended_queue_core_tb: errors");
    end
    $finish;
  end

  // Sender: bursts of requests with random gaps between them.
  always @(posedge clk) begin : sender
    deque_req_t r;
    int         burst_left;
    int         gap_left;
    int         pick;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      dq_head    = '0;
      dq_count   = '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && in_ready) begin
        outcome_q.push_back(deque_apply(op_t'(in_kind), in_value));
        accept_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (req_q[0].hold && outcome_q.size() != 0) begin
          // Let the core drain completely before this request goes out.
          in_valid <= 1'b0;
        end else begin
          r = req_q.pop_front();
          in_valid <= 1'b1;
          in_kind  <= r.kind;
          in_value <= r.word;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            pick       = $urandom_range(0, 9);
            if (pick < 3)      gap_left = 0;
            else if (pick < 8) gap_left = $urandom_range(1, 4);
            else if (pick < 9) gap_left = $urandom_range(5, 12);
            else               gap_left = $urandom_range(20, 40);
          end
        end
      end
    end
  end

  // Receiver: ready follows a stall mode that changes every so often.
  always @(posedge clk) begin : receiver
    int         mode;
    int         mode_left;
    logic [7:0] pattern;
    if (!rst_n) begin
      out_ready <= 1'b0;
      mode      = 0;
      mode_left = 0;
      pattern   = 8'h96;
    end else begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
        pattern   = 8'($urandom);
        if (pattern == 8'h00) pattern = 8'h96;
      end else begin
        mode_left--;
      end
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2: begin
          out_ready <= pattern[7];
          pattern    = {pattern[6:0], pattern[7]};
        end
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Checker: each result against the oldest predicted outcome.
  always @(posedge clk) begin : result_check
    deque_outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (outcome_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("result %0d arrived with no request outstanding", result_cnt);
      end else begin
        want = outcome_q.pop_front();
        check_field("popped_value", want.popped, out_popped_value);
        check_field("front_value", want.front, out_front_value);
        check_field("back_value", want.back, out_back_value);
        check_field("item_count", 32'(want.count), 32'(out_item_count));
        check_field("status", 32'(want.status), 32'(out_status));
      end
      result_cnt++;
    end
  end

  // Watchdog for a hung core.
  initial begin : watchdog
    #1000000;
    $display("double_ended_queue_core_tb: errors");
    $finish;
  end

endmodule
